// ===== rtl/btlp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the BER tag and length header parser.
// No dependencies; used by every module under rtl.
package btlp_pkg;

	localparam int TAG_W              = 28;
	localparam int LEN_W              = 32;
	localparam int MAX_TAG_GROUPS_DEF = 4;
	localparam int MAX_LEN_OCTETS_DEF = 4;

	localparam logic [7:0] CLASS_MASK = 8'hC0;
	localparam logic [7:0] CONS_MASK  = 8'h20;
	localparam logic [4:0] HIGH_TAG   = 5'h1F;
	localparam logic [TAG_W-1:0] SEQUENCE_TAG = TAG_W'(16);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HIGH_TAG,
		PH_LEN_FIRST,
		PH_LEN_MORE
	} phase_t;

	typedef enum logic [2:0] {
		ST_HEADER   = 3'd0,
		ST_EOC      = 3'd1,
		ST_END      = 3'd2,
		ST_OVERRUN  = 3'd3,
		ST_BAD_ID   = 3'd4,
		ST_TOO_LONG = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] octet;
		logic       buffer_end;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic [1:0]       tag_class;
		logic             constructed;
		logic [TAG_W-1:0] tag_number;
		logic [LEN_W-1:0] content_length;
		logic             indefinite;
	} result_t;

	typedef struct packed {
		logic item_valid;
		logic out_busy;
	} dec_ctl_in_t;

	typedef struct packed {
		logic advance;
		logic emit;
	} dec_ctl_out_t;

endpackage

// ===== rtl/btlp_in_reg.sv =====
`timescale 1ns / 1ps
// Input register for the header parser: holds one accepted octet request.
// Depends on btlp_pkg.
module btlp_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  btlp_pkg::item_t in_item,
	input  logic           advance,
	output logic           valid_s1,
	output btlp_pkg::item_t item_s1
);
	import btlp_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/btlp_decoder.sv =====
`timescale 1ns / 1ps
// Header decode step and parser state registers for one octet per cycle
// unless a result waits and the octet would emit one. Depends on btlp_pkg.
module btlp_decoder #(
	parameter int MAX_TAG_GROUPS = btlp_pkg::MAX_TAG_GROUPS_DEF,
	parameter int MAX_LEN_OCTETS = btlp_pkg::MAX_LEN_OCTETS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  btlp_pkg::dec_ctl_in_t  ctl_in,
	input  btlp_pkg::item_t        item,
	input  logic                   require_sequence,
	output btlp_pkg::dec_ctl_out_t ctl_out,
	output btlp_pkg::result_t      res
);
	import btlp_pkg::*;

	localparam int GW = $clog2(MAX_TAG_GROUPS + 1);
	localparam int LW = $clog2(MAX_LEN_OCTETS + 1);

	phase_t           phase_q, phase_d;
	logic             id_zero_q, id_zero_d;
	logic [1:0]       class_q, class_d;
	logic             cons_q, cons_d;
	logic [TAG_W-1:0] tag_q, tag_d;
	logic [GW-1:0]    groups_q, groups_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LW-1:0]    left_q, left_d;

	logic             emit;
	logic             bare;
	status_t          bare_status;
	logic [LEN_W-1:0] hdr_len;
	logic             hdr_indef;
	logic [GW-1:0]    groups_inc;
	logic [LW-1:0]    left_dec;
	logic [LEN_W-1:0] len_shift;
	logic [6:0]       n_octets;
	logic             not_sequence;

	assign groups_inc   = groups_q + GW'(1);
	assign left_dec     = (left_q != '0) ? left_q - LW'(1) : left_q;
	assign len_shift    = {len_q[LEN_W-9:0], item.octet};
	assign n_octets     = item.octet[6:0];
	assign not_sequence = (class_q != 2'd0) || !cons_q || (tag_q != SEQUENCE_TAG);

	always_comb begin
		phase_d     = phase_q;
		id_zero_d   = id_zero_q;
		class_d     = class_q;
		cons_d      = cons_q;
		tag_d       = tag_q;
		groups_d    = groups_q;
		len_d       = len_q;
		left_d      = left_q;
		emit        = 1'b0;
		bare        = 1'b0;
		bare_status = ST_END;
		hdr_len     = '0;
		hdr_indef   = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (item.buffer_end) begin
				emit        = 1'b1;
				bare        = 1'b1;
				bare_status = ST_END;
			end else begin
				class_d   = item.octet[7:6];
				cons_d    = |(item.octet & CONS_MASK);
				id_zero_d = (item.octet == 8'd0);
				groups_d  = '0;
				if (item.octet[4:0] == HIGH_TAG) begin
					tag_d   = '0;
					phase_d = PH_HIGH_TAG;
				end else begin
					tag_d   = TAG_W'(item.octet[4:0]);
					phase_d = PH_LEN_FIRST;
				end
			end
		end else if (item.buffer_end) begin
			emit        = 1'b1;
			bare        = 1'b1;
			bare_status = ST_OVERRUN;
		end else begin
			case (phase_q)
				PH_HIGH_TAG: begin
					if (tag_q[TAG_W-1:TAG_W-7] != 7'd0) begin
						emit        = 1'b1;
						bare        = 1'b1;
						bare_status = ST_TOO_LONG;
					end else begin
						tag_d    = {tag_q[TAG_W-8:0], item.octet[6:0]};
						groups_d = groups_inc;
						if (item.octet[7]) begin
							if (groups_inc >= GW'(MAX_TAG_GROUPS)) begin
								emit        = 1'b1;
								bare        = 1'b1;
								bare_status = ST_TOO_LONG;
							end
						end else begin
							phase_d = PH_LEN_FIRST;
						end
					end
				end
				PH_LEN_FIRST: begin
					if (id_zero_q && item.octet == 8'd0) begin
						emit        = 1'b1;
						bare        = 1'b1;
						bare_status = ST_EOC;
					end else if (!item.octet[7]) begin
						emit    = 1'b1;
						hdr_len = LEN_W'(n_octets);
					end else if (n_octets == 7'd0) begin
						emit      = 1'b1;
						hdr_indef = 1'b1;
					end else if (n_octets > 7'(MAX_LEN_OCTETS)) begin
						emit        = 1'b1;
						bare        = 1'b1;
						bare_status = ST_TOO_LONG;
					end else begin
						len_d   = '0;
						left_d  = n_octets[LW-1:0];
						phase_d = PH_LEN_MORE;
					end
				end
				PH_LEN_MORE: begin
					if (len_q[LEN_W-1:LEN_W-8] != 8'd0) begin
						emit        = 1'b1;
						bare        = 1'b1;
						bare_status = ST_TOO_LONG;
					end else begin
						len_d  = len_shift;
						left_d = left_dec;
						if (left_dec == '0) begin
							emit      = 1'b1;
							hdr_len   = len_shift;
							hdr_indef = (len_shift == '0);
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		if (emit) begin
			phase_d = PH_IDLE;
		end
	end

	always_comb begin
		if (bare) begin
			res.status = bare_status;
			if (require_sequence && (bare_status == ST_EOC || bare_status == ST_END)) begin
				res.status = ST_BAD_ID;
			end
			res.tag_class      = '0;
			res.constructed    = 1'b0;
			res.tag_number     = '0;
			res.content_length = '0;
			res.indefinite     = 1'b0;
		end else begin
			res.status         = (require_sequence && not_sequence) ? ST_BAD_ID : ST_HEADER;
			res.tag_class      = class_q;
			res.constructed    = cons_q;
			res.tag_number     = tag_q;
			res.content_length = hdr_len;
			res.indefinite     = hdr_indef;
		end
	end

	assign ctl_out.emit    = ctl_in.item_valid && emit;
	assign ctl_out.advance = ctl_in.item_valid && (!emit || !ctl_in.out_busy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			id_zero_q <= 1'b0;
			class_q   <= '0;
			cons_q    <= 1'b0;
			tag_q     <= '0;
			groups_q  <= '0;
			len_q     <= '0;
			left_q    <= '0;
		end else if (ctl_out.advance) begin
			phase_q   <= phase_d;
			id_zero_q <= id_zero_d;
			class_q   <= class_d;
			cons_q    <= cons_d;
			tag_q     <= tag_d;
			groups_q  <= groups_d;
			len_q     <= len_d;
			left_q    <= left_d;
		end
	end

endmodule

// ===== rtl/ber_tag_length_parser.sv =====
`timescale 1ns / 1ps
// Top level of the BER tag and length header parser: input register,
// decoder, configuration register and result register. Depends on btlp_pkg,
// btlp_in_reg and btlp_decoder.
//
// Takes one octet request per clock cycle, but for the stall named below,
// and emits at most one result per header once the header ends (normally,
// at an error, or at a buffer end marker). After its last octet is
// accepted, a result passes through the input register, then the result
// register. The per-octet decode is a single short pass over the header
// state, so a result waiting in the result register stalls input only when
// the next octet would itself produce a result. require_sequence is written
// through its own port, which is always ready, and must be changed only
// while the parser is idle.
module ber_tag_length_parser #(
	parameter int MAX_TAG_GROUPS = btlp_pkg::MAX_TAG_GROUPS_DEF,
	parameter int MAX_LEN_OCTETS = btlp_pkg::MAX_LEN_OCTETS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       require_sequence,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 octet,
	input  logic                       buffer_end,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 status,
	output logic [1:0]                 tag_class,
	output logic                       constructed,
	output logic [btlp_pkg::TAG_W-1:0] tag_number,
	output logic [btlp_pkg::LEN_W-1:0] content_length,
	output logic                       indefinite
);
	import btlp_pkg::*;

	logic         req_seq_q;
	logic         valid_s1;
	item_t        in_item;
	item_t        item_s1;
	dec_ctl_in_t  dec_in;
	dec_ctl_out_t dec_out;
	result_t      res;
	result_t      res_q;
	logic         out_valid_q;

	assign cfg_ready          = 1'b1;
	assign in_item.octet      = octet;
	assign in_item.buffer_end = buffer_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_seq_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			req_seq_q <= require_sequence;
		end
	end

	btlp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (dec_out.advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	assign dec_in.item_valid = valid_s1;
	assign dec_in.out_busy   = out_valid_q && !out_ready;

	btlp_decoder #(
		.MAX_TAG_GROUPS (MAX_TAG_GROUPS),
		.MAX_LEN_OCTETS (MAX_LEN_OCTETS)
	) u_decoder (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl_in           (dec_in),
		.item             (item_s1),
		.require_sequence (req_seq_q),
		.ctl_out          (dec_out),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dec_out.advance && dec_out.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_out.advance && dec_out.emit) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign tag_class      = res_q.tag_class;
	assign constructed    = res_q.constructed;
	assign tag_number     = res_q.tag_number;
	assign content_length = res_q.content_length;
	assign indefinite     = res_q.indefinite;

endmodule

// ===== dv/ber_tag_length_parser_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ber_tag_length_parser: directed and random octet streams
// with random stalls on both sides, checked against an in-bench header decoder.
// Depends on btlp_pkg and the parser RTL only.
module ber_tag_length_parser_tb;
	import btlp_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               require_sequence = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         octet = 8'h00;
	logic               buffer_end = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic [1:0]         tag_class;
	logic               constructed;
	logic [TAG_W-1:0]   tag_number;
	logic [LEN_W-1:0]   content_length;
	logic               indefinite;

	ber_tag_length_parser dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.require_sequence (require_sequence),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.octet            (octet),
		.buffer_end       (buffer_end),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.tag_class        (tag_class),
		.constructed      (constructed),
		.tag_number       (tag_number),
		.content_length   (content_length),
		.indefinite       (indefinite)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	result_t          pending_headers[$];
	int               errors = 0;
	int               octets_sent = 0;
	int               quiet_cycles = 0;
	bit               tx_idles = 1'b1;
	bit               rx_idles = 1'b1;
	bit               hold_results = 1'b0;
	bit               offering = 1'b0;

	// decoder state
	bit               seq_only = 1'b0;
	phase_t           hdr_phase = PH_IDLE;
	bit               id_zero = 1'b0;
	logic [1:0]       cls = '0;
	logic             cons = 1'b0;
	logic [TAG_W-1:0] tag_acc = '0;
	int               groups_seen = 0;
	logic [LEN_W-1:0] len_acc = '0;
	logic [6:0]       len_left = '0;

	function automatic void post_bare(status_t st);
		result_t r;
		if (seq_only && (st == ST_EOC || st == ST_END))
			st = ST_BAD_ID;
		r = '0;
		r.status = st;
		pending_headers.push_back(r);
		hdr_phase = PH_IDLE;
	endfunction

	function automatic void post_header(logic [LEN_W-1:0] len, logic indef);
		result_t r;
		r.status = (seq_only && (cls != 2'd0 || !cons || tag_acc != SEQUENCE_TAG)) ?
			ST_BAD_ID : ST_HEADER;
		r.tag_class = cls;
		r.constructed = cons;
		r.tag_number = tag_acc;
		r.content_length = len;
		r.indefinite = indef;
		pending_headers.push_back(r);
		hdr_phase = PH_IDLE;
	endfunction

	function automatic void decode_octet(logic [7:0] b, logic e);
		logic [6:0] cnt;
		cnt = b[6:0];
		if (hdr_phase == PH_IDLE) begin
			if (e) begin
				post_bare(ST_END);
			end else begin
				cls = b[7:6];
				cons = b[5];
				id_zero = (b == 8'h00);
				groups_seen = 0;
				if (b[4:0] == HIGH_TAG) begin
					tag_acc = '0;
					hdr_phase = PH_HIGH_TAG;
				end else begin
					tag_acc = TAG_W'(b[4:0]);
					hdr_phase = PH_LEN_FIRST;
				end
			end
		end else if (e) begin
			post_bare(ST_OVERRUN);
		end else begin
			case (hdr_phase)
				PH_HIGH_TAG: begin
					if (tag_acc[TAG_W-1:21] != '0) begin
						post_bare(ST_TOO_LONG);
					end else begin
						tag_acc = {tag_acc[20:0], b[6:0]};
						groups_seen++;
						if (!b[7])
							hdr_phase = PH_LEN_FIRST;
						else if (groups_seen >= MAX_TAG_GROUPS_DEF)
							post_bare(ST_TOO_LONG);
					end
				end
				PH_LEN_FIRST: begin
					if (id_zero && b == 8'h00)
						post_bare(ST_EOC);
					else if (!b[7])
						post_header(LEN_W'(cnt), 1'b0);
					else if (cnt == 7'd0)
						post_header('0, 1'b1);
					else if (cnt > MAX_LEN_OCTETS_DEF)
						post_bare(ST_TOO_LONG);
					else begin
						len_acc = '0;
						len_left = cnt;
						hdr_phase = PH_LEN_MORE;
					end
				end
				default: begin
					if (len_acc[LEN_W-1:24] != '0) begin
						post_bare(ST_TOO_LONG);
					end else begin
						len_acc = {len_acc[23:0], b};
						if (len_left > 0)
							len_left--;
						if (len_left == 0)
							post_header(len_acc, len_acc == '0);
					end
				end
			endcase
		end
	endfunction

	// offer one request, keep valid high afterwards until the next call decides
	task automatic send_octet(input logic [7:0] b, input logic e);
		int gap;
		gap = tx_idles ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			if (offering)
				in_valid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
		octet <= b;
		buffer_end <= e;
		in_valid <= 1'b1;
		offering = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		decode_octet(b, e);
		octets_sent++;
	endtask

	task automatic wait_drained();
		if (offering)
			in_valid <= 1'b0;
		offering = 1'b0;
		while (pending_headers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic close_header();
		if (hdr_phase != PH_IDLE)
			send_octet(8'($urandom), 1'b1);
	endtask

	task automatic set_mode(input logic v);
		close_header();
		wait_drained();
		cfg_valid <= 1'b1;
		require_sequence <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		seq_only = v;
	endtask

	task automatic send_random_header();
		int pick, n, i;
		logic [7:0] id;
		logic more;
		logic zero_len;
		pick = $urandom_range(0, 99);
		id = {3'($urandom), 5'($urandom_range(0, 30))};
		if (pick < 72) begin
			if (seq_only && $urandom_range(0, 1) == 1)
				id = 8'h30;
			if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, MAX_TAG_GROUPS_DEF);
				send_octet(id | 8'h1F, 1'b0);
				for (i = 0; i < n; i++) begin
					more = (i < n - 1);
					send_octet({more, 7'($urandom)}, 1'b0);
				end
			end else begin
				send_octet(id, 1'b0);
			end
			case ($urandom_range(0, 3))
				0: send_octet({1'b0, 7'($urandom)}, 1'b0);
				1: send_octet(8'h80, 1'b0);
				default: begin
					n = $urandom_range(1, MAX_LEN_OCTETS_DEF);
					zero_len = ($urandom_range(0, 4) == 0);
					send_octet({1'b1, 7'(n)}, 1'b0);
					for (i = 0; i < n; i++)
						send_octet(zero_len ? 8'h00 : 8'($urandom), 1'b0);
				end
			endcase
		end else if (pick < 80) begin
			send_octet(8'h00, 1'b0);
			send_octet(8'h00, 1'b0);
		end else if (pick < 85) begin
			send_octet(8'($urandom), 1'b1);
		end else if (pick < 90) begin
			send_octet(id, 1'b0);
			if ($urandom_range(0, 1) == 1) begin
				send_octet(8'h84, 1'b0);
				repeat ($urandom_range(0, 3)) send_octet(8'($urandom), 1'b0);
			end
			send_octet(8'($urandom), 1'b1);
		end else if (pick < 94) begin
			send_octet(id | 8'h1F, 1'b0);
			repeat (MAX_TAG_GROUPS_DEF) send_octet(8'($urandom) | 8'h80, 1'b0);
		end else if (pick < 97) begin
			send_octet(id, 1'b0);
			send_octet({1'b1, 7'($urandom_range(MAX_LEN_OCTETS_DEF + 1, 127))}, 1'b0);
		end else begin
			repeat ($urandom_range(1, 4))
				send_octet(8'($urandom), $urandom_range(0, 7) == 0);
		end
	endtask

	task automatic random_stream(input int count);
		int stop_at;
		stop_at = octets_sent + count;
		while (octets_sent < stop_at) send_random_header();
		close_header();
	endtask

	task automatic test_basic_headers();
		// class 3, primitive, largest short tag, largest short length
		send_octet(8'hDE, 1'b0);
		send_octet(8'h7F, 1'b0);
		// largest high-form tag and largest long-form length
		send_octet(8'hFF, 1'b0);
		send_octet(8'hFF, 1'b0);
		send_octet(8'hFF, 1'b0);
		send_octet(8'hFF, 1'b0);
		send_octet(8'h7F, 1'b0);
		send_octet(8'h84, 1'b0);
		repeat (4) send_octet(8'hFF, 1'b0);
		// long form that decodes to zero
		send_octet(8'h04, 1'b0);
		send_octet(8'h81, 1'b0);
		send_octet(8'h00, 1'b0);
		send_octet(8'h00, 1'b0);
		send_octet(8'h00, 1'b0);
		send_octet(8'hA5, 1'b1);
		send_octet(8'h30, 1'b0);
		send_octet(8'h00, 1'b1);
		send_octet(8'h1F, 1'b0);
		repeat (MAX_TAG_GROUPS_DEF) send_octet(8'h81, 1'b0);
		send_octet(8'h04, 1'b0);
		send_octet(8'h85, 1'b0);
	endtask

	task automatic test_sequence_mode();
		set_mode(1'b1);
		send_octet(8'h30, 1'b0);
		send_octet(8'h80, 1'b0);
		send_octet(8'h10, 1'b0);
		send_octet(8'h01, 1'b0);
		send_octet(8'h00, 1'b0);
		send_octet(8'h00, 1'b0);
		send_octet(8'h5A, 1'b1);
		send_octet(8'h30, 1'b0);
		send_octet(8'hFF, 1'b1);
		set_mode(1'b0);
	endtask

	task automatic test_result_stall();
		tx_idles = 1'b0;
		hold_results = 1'b1;
		repeat (40) begin
			send_octet(8'h30, 1'b0);
			send_octet({1'b0, 7'($urandom)}, 1'b0);
		end
		wait_drained();
		tx_idles = 1'b1;
	endtask

	task automatic test_random_stream();
		tx_idles = 1'b1;
		rx_idles = 1'b1;
		random_stream(400);
		set_mode(1'b1);
		random_stream(350);
		tx_idles = 1'b0;
		rx_idles = 1'b0;
		random_stream(200);
		set_mode(1'b0);
		tx_idles = 1'b1;
		random_stream(200);
		tx_idles = 1'b0;
		rx_idles = 1'b1;
		random_stream(200);
	endtask

	initial begin : result_checker
		int stall;
		result_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				stall = HOLD_CYCLES;
				hold_results = 1'b0;
			end else begin
				stall = rx_idles ? $urandom_range(0, 6) : 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (pending_headers.size() == 0) begin
				$error("unexpected result: status %0d", status);
				errors++;
			end else begin
				want = pending_headers.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (tag_class !== want.tag_class) begin
					$error("tag_class: expected %0d, got %0d", want.tag_class, tag_class);
					errors++;
				end
				if (constructed !== want.constructed) begin
					$error("constructed: expected %0d, got %0d", want.constructed,
						constructed);
					errors++;
				end
				if (tag_number !== want.tag_number) begin
					$error("tag_number: expected %0h, got %0h", want.tag_number, tag_number);
					errors++;
				end
				if (content_length !== want.content_length) begin
					$error("content_length: expected %0h, got %0h", want.content_length,
						content_length);
					errors++;
				end
				if (indefinite !== want.indefinite) begin
					$error("indefinite: expected %0d, got %0d", want.indefinite, indefinite);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_headers();
		test_sequence_mode();
		test_result_stall();
		test_random_stream();
		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
